// File: hw/rtl/hpsc_pkg.sv
// ----------------------------------------------------------------------------
// hpsc_pkg
// shared widths, constants, configuration types and stage control structs
// ----------------------------------------------------------------------------
package hpsc_pkg;

  localparam int TEMP_W    = 12;
  localparam int DRIVE_W   = 8;
  localparam int GAIN_W    = 32;
  localparam int LIMIT_W   = 15;
  localparam int HYST_W    = 8;
  localparam int ACC_W     = 17;
  localparam int LAG_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int GAIN_SCALE_DEF    = 1024;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX      = 8'hFF;
  localparam logic [LAG_W-1:0]   HEAT_LAG_TICKS = 7'd40;
  localparam logic [LAG_W-1:0]   COOL_LAG_TICKS = 7'd125;
  localparam logic [TEMP_W-1:0]  COOL_FLOOR     = 12'd240;

  typedef enum logic {
    MODE_PID  = 1'b0,
    MODE_BANG = 1'b1
  } ctrl_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN     = 3'd0,
    CFG_I_GAIN     = 3'd1,
    CFG_D_GAIN     = 3'd2,
    CFG_INT_LIMIT  = 3'd3,
    CFG_HYSTERESIS = 3'd4,
    CFG_MODE       = 3'd5,
    CFG_BANG_ON    = 3'd6,
    CFG_BANG_OFF   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] p_gain;
    logic signed [GAIN_W-1:0] i_gain;
    logic signed [GAIN_W-1:0] d_gain;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [HYST_W-1:0]        hysteresis;
    ctrl_mode_e               mode;
    logic [DRIVE_W-1:0]       bang_on_level;
    logic [DRIVE_W-1:0]       bang_off_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    p_gain:         '0,
    i_gain:         '0,
    d_gain:         '0,
    integral_limit: '0,
    hysteresis:     8'd4,
    mode:           MODE_PID,
    bang_on_level:  8'd255,
    bang_off_level: 8'd0
  };

  // control word carried from the compute stage toward the output
  typedef struct packed {
    logic               use_div;   // drive comes from the scaled gain sum
    logic [DRIVE_W-1:0] drv;       // drive when the divider is bypassed
    logic               fault;
    logic               upd_last;  // pid transaction: write last drive at the end
  } stage_ctl_t;

  // final result of one transaction
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               fault;
    logic               upd_last;
  } result_t;

  // late write of the last drive from the output side
  typedef struct packed {
    logic               en;
    logic [DRIVE_W-1:0] val;
  } last_wr_t;

endpackage

// File: hw/rtl/hpsc_history.sv
// ----------------------------------------------------------------------------
// hpsc_history
// temperature history ring with prefetched read of the oldest entry
// ----------------------------------------------------------------------------
module hpsc_history import hpsc_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [TEMP_W-1:0] wr_data_i,
  output logic [TEMP_W-1:0] oldest_o
);

  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    logic [PW:0] inc;
    inc = {1'b0, p} + (PW+1)'(1);
    if (inc >= (PW+1)'(HISTORY_DEPTH)) begin
      return '0;
    end
    return inc[PW-1:0];
  endfunction

  logic [TEMP_W-1:0]        mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_q;
  logic [PW-1:0]            ptr_q, ptr_d;
  logic [PW-1:0]            raddr;
  logic                     byp;
  logic [TEMP_W-1:0]        rd_q;
  logic                     rd_vld_q;
  logic                     byp_q;
  logic [TEMP_W-1:0]        byp_data_q;

  // read for the next transaction goes one past the new pointer
  assign ptr_d = ptr_next(ptr_q);
  assign raddr = ptr_next(ptr_d);
  assign byp   = (raddr == ptr_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[ptr_q] <= wr_data_i;
      rd_q       <= mem[raddr];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else if (wr_en_i) begin
      ptr_q        <= ptr_d;
      vld_q[ptr_q] <= 1'b1;
      rd_vld_q     <= vld_q[raddr];
      byp_q        <= byp;
    end
  end

  // entries never written read as zero
  assign oldest_o = byp_q    ? byp_data_q :
                    rd_vld_q ? rd_q       : '0;

endmodule

// File: hw/rtl/hpsc_core.sv
// ----------------------------------------------------------------------------
// hpsc_core
// control law, integrator, sanity tracker and controller state
// ----------------------------------------------------------------------------
module hpsc_core import hpsc_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int GAIN_SCALE    = GAIN_SCALE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                fire_i,
  input  logic [TEMP_W-1:0]   cur_i,
  input  logic [TEMP_W-1:0]   tgt_i,
  input  last_wr_t            last_wr_i,
  output stage_ctl_t          ctl_o,
  output logic [$clog2((int'(DRIVE_MAX) + 1) * GAIN_SCALE)-1:0] x_o
);

  localparam int XW     = $clog2((int'(DRIVE_MAX) + 1) * GAIN_SCALE);
  localparam int EP_W   = TEMP_W + 1 + GAIN_W;
  localparam int AP_W   = ACC_W + GAIN_W;
  localparam int SUM_W  = AP_W + 2;
  localparam int CMP_W  = TEMP_W + 2;
  localparam logic signed [SUM_W-1:0] HI_THR = SUM_W'((int'(DRIVE_MAX) + 1) * GAIN_SCALE);
  localparam logic signed [SUM_W-1:0] LO_THR = SUM_W'(-GAIN_SCALE);

  logic signed [ACC_W-1:0] integral_q;
  logic [TEMP_W-1:0]       sane_q;
  logic [LAG_W-1:0]        lag_q;
  logic [DRIVE_W-1:0]      last_drive_q;

  logic [TEMP_W-1:0]       oldest;
  logic                    tgt_zero, is_pid, hist_wr;

  logic signed [TEMP_W:0]  err, deriv;
  logic signed [ACC_W:0]   acc_sum, lim, neg_lim, acc_back;
  logic signed [ACC_W-1:0] acc_c, acc_n;
  logic signed [EP_W-1:0]  prod_p, prod_d;
  logic signed [AP_W-1:0]  prod_i;
  logic signed [SUM_W-1:0] sum;
  logic                    sat_hi, sat_lo;

  logic [CMP_W-1:0]        c14, t14, h14, w14;
  logic                    off_hit, on_hit;
  logic [DRIVE_W-1:0]      drv_bang;

  logic                    heat, cool;
  logic signed [TEMP_W:0]  s, diff, diff_abs;
  logic [LAG_W-1:0]        lag_n;
  logic                    fault;

  assign tgt_zero = (tgt_i == '0);
  assign is_pid   = (cfg_i.mode == MODE_PID);
  assign hist_wr  = fire_i && !tgt_zero && is_pid;

  hpsc_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (hist_wr),
    .wr_data_i (cur_i),
    .oldest_o  (oldest)
  );

  // pid terms
  assign err     = $signed({1'b0, tgt_i}) - $signed({1'b0, cur_i});
  assign deriv   = $signed({1'b0, oldest}) - $signed({1'b0, cur_i});
  assign acc_sum = $signed({integral_q[ACC_W-1], integral_q})
                 + $signed({{(ACC_W-TEMP_W){err[TEMP_W]}}, err});
  assign lim     = $signed({{(ACC_W+1-LIMIT_W){1'b0}}, cfg_i.integral_limit});
  assign neg_lim = -lim;

  always_comb begin
    if (acc_sum > lim) begin
      acc_c = lim[ACC_W-1:0];
    end else if (acc_sum < neg_lim) begin
      acc_c = neg_lim[ACC_W-1:0];
    end else begin
      acc_c = acc_sum[ACC_W-1:0];
    end
  end

  assign prod_p = EP_W'(err)   * EP_W'($signed(cfg_i.p_gain));
  assign prod_i = AP_W'(acc_c) * AP_W'($signed(cfg_i.i_gain));
  assign prod_d = EP_W'(deriv) * EP_W'($signed(cfg_i.d_gain));
  assign sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  // quotient above the drive range or below zero, decided on the raw sum
  assign sat_hi = (sum >= HI_THR);
  assign sat_lo = (sum <= LO_THR);

  assign acc_back = $signed({acc_c[ACC_W-1], acc_c})
                  - $signed({{(ACC_W-TEMP_W){err[TEMP_W]}}, err});

  always_comb begin
    if ((sat_hi && (err > 0)) || (sat_lo && (err < 0))) begin
      acc_n = acc_back[ACC_W-1:0];
    end else begin
      acc_n = acc_c;
    end
  end

  // bang-bang thresholds, compared without going negative
  assign c14 = {2'b00, cur_i};
  assign t14 = {2'b00, tgt_i};
  assign h14 = CMP_W'(cfg_i.hysteresis);
  assign w14 = CMP_W'({cfg_i.hysteresis, 2'b00});

  assign off_hit  = (c14 >= t14 + h14);
  assign on_hit   = (c14 + h14 <= t14);
  assign drv_bang = off_hit ? cfg_i.bang_off_level :
                    on_hit  ? cfg_i.bang_on_level  : last_drive_q;

  // sanity tracker
  assign heat = (t14 > c14 + w14);
  assign cool = (t14 + w14 < c14);

  always_comb begin
    s     = $signed({1'b0, sane_q});
    lag_n = lag_q;
    if (heat) begin
      if (cur_i > sane_q) begin
        s = $signed({1'b0, cur_i});
      end else if (lag_q < HEAT_LAG_TICKS) begin
        lag_n = lag_q + LAG_W'(1);
      end else begin
        lag_n = '0;
        // a step past the target lands on the target
        s     = (sane_q < tgt_i) ? $signed({1'b0, sane_q}) + 13'sd1
                                 : $signed({1'b0, tgt_i});
      end
      if (s > $signed({1'b0, tgt_i})) begin
        s = $signed({1'b0, tgt_i});
      end
    end else if (cool) begin
      if (cur_i < sane_q) begin
        s = $signed({1'b0, cur_i});
      end else if (lag_q < COOL_LAG_TICKS) begin
        lag_n = lag_q + LAG_W'(1);
      end else begin
        lag_n = '0;
        s     = $signed({1'b0, sane_q}) - 13'sd1;
      end
      if (cur_i <= COOL_FLOOR) begin
        s = $signed({1'b0, cur_i});
      end else if (s < $signed({1'b0, tgt_i})) begin
        s = $signed({1'b0, tgt_i});
      end
    end else begin
      s     = $signed({1'b0, cur_i});
      lag_n = '0;
    end
  end

  assign diff     = $signed({1'b0, cur_i}) - s;
  assign diff_abs = diff[TEMP_W] ? -diff : diff;
  assign fault    = ($unsigned(diff_abs) > (TEMP_W+1)'({cfg_i.hysteresis, 2'b00}));

  // stage control word
  always_comb begin
    ctl_o = '0;
    if (!tgt_zero) begin
      if (fault) begin
        ctl_o.fault    = 1'b1;
        ctl_o.upd_last = is_pid;
      end else if (is_pid) begin
        ctl_o.use_div  = !sat_hi && !sat_lo && !sum[SUM_W-1];
        ctl_o.drv      = sat_hi ? DRIVE_MAX : '0;
        ctl_o.upd_last = 1'b1;
      end else begin
        ctl_o.drv      = drv_bang;
      end
    end
  end

  assign x_o = sum[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q   <= '0;
      sane_q       <= '0;
      lag_q        <= '0;
      last_drive_q <= '0;
    end else begin
      if (fire_i && !tgt_zero) begin
        sane_q <= s[TEMP_W-1:0];
        lag_q  <= lag_n;
        if (is_pid) begin
          integral_q <= acc_n;
        end else begin
          last_drive_q <= fault ? '0 : drv_bang;
        end
      end
      if (last_wr_i.en) begin
        last_drive_q <= last_wr_i.val;
      end
    end
  end

endmodule

// File: hw/rtl/hpsc_divider.sv
// ----------------------------------------------------------------------------
// hpsc_divider
// divides the in-range gain sum by the gain scale: reciprocal then correction
// ----------------------------------------------------------------------------
module hpsc_divider import hpsc_pkg::*; #(
  parameter int GAIN_SCALE = GAIN_SCALE_DEF
) (
  input  logic       clk_i,
  input  logic       load_i,
  input  stage_ctl_t ctl_i,
  input  logic [$clog2((int'(DRIVE_MAX) + 1) * GAIN_SCALE)-1:0] x_i,
  output result_t    res_o
);

  localparam int XW      = $clog2((int'(DRIVE_MAX) + 1) * GAIN_SCALE);
  localparam int RECIP_W = 10;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << XW) / GAIN_SCALE);
  localparam logic [XW-1:0]      SCALE = XW'(GAIN_SCALE);

  logic [XW+RECIP_W-1:0] prod;
  logic [DRIVE_W-1:0]    q0_d, q0_q;
  logic [XW-1:0]         x_q;
  stage_ctl_t            ctl_q;
  logic [XW-1:0]         qs, rem;
  logic [DRIVE_W-1:0]    q;

  // estimate is the quotient or one below it
  assign prod = (XW+RECIP_W)'(x_i) * (XW+RECIP_W)'(RECIP);
  assign q0_d = prod[XW+DRIVE_W-1:XW];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q0_q  <= q0_d;
      x_q   <= x_i;
      ctl_q <= ctl_i;
    end
  end

  assign qs  = XW'(q0_q) * SCALE;
  assign rem = x_q - qs;
  assign q   = (rem >= SCALE) ? q0_q + DRIVE_W'(1) : q0_q;

  assign res_o.drive    = ctl_q.use_div ? q : ctl_q.drv;
  assign res_o.fault    = ctl_q.fault;
  assign res_o.upd_last = ctl_q.upd_last;

endmodule

// File: hw/rtl/heater_pid_with_sanity_check.sv
// ----------------------------------------------------------------------------
// heater_pid_with_sanity_check
// per-heater temperature controller: pid or bang-bang drive with a
// heating/cooling sanity tracker that cuts the heater on a lagging sensor
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (32b)
//  in      | in        | in_valid/in_ready   | measured_temp, setpoint (12b)
//  out     | out       | out_valid/out_ready | drive (8b), sensor_fault (1b)
//
//  one transaction per cycle sustained while the output is not stalled; a
//  result passes the input, compute, divide and output registers in turn
//  the rate is set by the integrator loop in the compute stage: the gain
//  multiplies, sum and saturation compares close combinationally on the state
//  every stage holds on a stall and bubbles collapse, so input flows into empty
//  stages while a result waits; reset clears all state, history reads as zero
//
module heater_pid_with_sanity_check import hpsc_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int GAIN_SCALE    = GAIN_SCALE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  // temperature samples
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TEMP_W-1:0]    measured_temp_i,
  input  logic [TEMP_W-1:0]    setpoint_i,
  // heater results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DRIVE_W-1:0]   drive_o,
  output logic                 sensor_fault_o
);

  localparam int XW = $clog2((int'(DRIVE_MAX) + 1) * GAIN_SCALE);

  cfg_t cfg_q;

  // stage valids: a input, b computed, c divided, d output register
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic a_rdy, b_rdy, c_rdy, d_rdy;

  logic [TEMP_W-1:0]  a_cur_q, a_tgt_q;
  stage_ctl_t         b_ctl_d, b_ctl_q;
  logic [XW-1:0]      b_x_d, b_x_q;
  result_t            c_res;
  logic [DRIVE_W-1:0] d_drive_q;
  logic               d_fault_q;
  last_wr_t           last_wr;
  logic               fire_a, load_c, load_d;

  // ready chain, each stage takes a new transaction when empty or draining
  assign d_rdy = !d_v_q || out_ready_i;
  assign c_rdy = !c_v_q || d_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;

  assign in_ready_o  = a_rdy;
  assign cfg_ready_o = 1'b1;

  assign fire_a = a_v_q && b_rdy;
  assign load_c = b_v_q && c_rdy;
  assign load_d = c_v_q && d_rdy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_P_GAIN:     cfg_q.p_gain         <= $signed(cfg_data_i);
        CFG_I_GAIN:     cfg_q.i_gain         <= $signed(cfg_data_i);
        CFG_D_GAIN:     cfg_q.d_gain         <= $signed(cfg_data_i);
        CFG_INT_LIMIT:  cfg_q.integral_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_HYSTERESIS: cfg_q.hysteresis     <= cfg_data_i[HYST_W-1:0];
        CFG_MODE:       cfg_q.mode           <= ctrl_mode_e'(cfg_data_i[0]);
        CFG_BANG_ON:    cfg_q.bang_on_level  <= cfg_data_i[DRIVE_W-1:0];
        CFG_BANG_OFF:   cfg_q.bang_off_level <= cfg_data_i[DRIVE_W-1:0];
      endcase
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_v_q <= a_v_q;
      end
      if (c_rdy) begin
        c_v_q <= b_v_q;
      end
      if (d_rdy) begin
        d_v_q <= c_v_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_rdy) begin
      a_cur_q <= measured_temp_i;
      a_tgt_q <= setpoint_i;
    end
    if (fire_a) begin
      b_ctl_q <= b_ctl_d;
      b_x_q   <= b_x_d;
    end
    if (load_d) begin
      d_drive_q <= c_res.drive;
      d_fault_q <= c_res.fault;
    end
  end

  // state advances as a transaction leaves the input register
  hpsc_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .GAIN_SCALE    (GAIN_SCALE)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .fire_i    (fire_a),
    .cur_i     (a_cur_q),
    .tgt_i     (a_tgt_q),
    .last_wr_i (last_wr),
    .ctl_o     (b_ctl_d),
    .x_o       (b_x_d)
  );

  hpsc_divider #(
    .GAIN_SCALE (GAIN_SCALE)
  ) u_divider (
    .clk_i  (clk_i),
    .load_i (load_c),
    .ctl_i  (b_ctl_q),
    .x_i    (b_x_q),
    .res_o  (c_res)
  );

  // pid drive is only final here; bang-bang writes its own in the core
  assign last_wr.en  = load_d && c_res.upd_last;
  assign last_wr.val = c_res.drive;

  assign out_valid_o    = d_v_q;
  assign drive_o        = d_drive_q;
  assign sensor_fault_o = d_fault_q;

  // a raised fault always comes with the heater off
  a_fault_drive_off: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_fault_o |-> drive_o == '0
  ) else $error("fault reported with nonzero drive");

  // input may only stall when the output side is stalled too
  a_stall_cause: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i
  ) else $error("input stalled without output backpressure");

  // a transaction taken into an empty pipeline shows up as out_valid
  // after it has passed the input, compute, divide and output registers
  a_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !a_v_q && !b_v_q && !c_v_q && !d_v_q
      |-> ##4 out_valid_o
  ) else $error("result missing after pipeline latency");

endmodule

// File: bench/heater_pid_with_sanity_check_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_pid_with_sanity_check_checker
// watches the cfg, sample and result channels, keeps its own copy of the
// controller state and compares every result transaction with its prediction
// ----------------------------------------------------------------------------
module heater_pid_with_sanity_check_checker import hpsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TEMP_W-1:0]    measured_temp_i,
  input  logic [TEMP_W-1:0]    setpoint_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DRIVE_W-1:0]   drive_i,
  input  logic                 sensor_fault_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               fault;
  } heater_cmd_t;

  // register copy
  int                 p_gain_q;
  int                 i_gain_q;
  int                 d_gain_q;
  int                 limit_q;
  int                 hyst_q;
  ctrl_mode_e         mode_q;
  logic [DRIVE_W-1:0] bang_on_q;
  logic [DRIVE_W-1:0] bang_off_q;

  // controller state copy
  int                 integ_q;
  int                 hist_q [HISTORY_DEPTH_DEF];
  int                 hist_ptr_q;
  logic [DRIVE_W-1:0] last_drive_q;
  int                 sane_q;
  int                 lag_q;

  heater_cmd_t        heater_cmd_q [$];
  int                 mismatches;

  function automatic heater_cmd_t predict_tick(input int cur, input int tgt);
    heater_cmd_t        r;
    int                 window;
    int                 err;
    int                 acc;
    int                 deriv;
    int                 diff;
    int                 ptr;
    longint             sum;
    longint             q;
    logic [DRIVE_W-1:0] drv;
    logic               flt;
    window = hyst_q * 4;
    drv    = last_drive_q;
    flt    = 1'b0;
    // heater off: nothing moves
    if (tgt == 0) begin
      r.drive = '0;
      r.fault = 1'b0;
      return r;
    end
    if (mode_q == MODE_PID) begin
      err = tgt - cur;
      ptr = hist_ptr_q;
      hist_q[ptr] = cur;
      ptr = (ptr + 1 >= HISTORY_DEPTH_DEF) ? 0 : ptr + 1;
      hist_ptr_q = ptr;
      acc = integ_q + err;
      if (acc > limit_q) begin
        acc = limit_q;
      end else if (acc < -limit_q) begin
        acc = -limit_q;
      end
      deriv = hist_q[ptr] - cur;
      sum = longint'(err) * longint'(p_gain_q) + longint'(acc) * longint'(i_gain_q)
          + longint'(deriv) * longint'(d_gain_q);
      q = sum / longint'(GAIN_SCALE_DEF);
      // anti-windup: undo this error when it pushed into saturation
      if (q > longint'(DRIVE_MAX)) begin
        if (err > 0) acc -= err;
        drv = DRIVE_MAX;
      end else if (q < 0) begin
        if (err < 0) acc -= err;
        drv = '0;
      end else begin
        drv = q[DRIVE_W-1:0];
      end
      integ_q = acc;
    end else begin
      if (cur >= tgt + hyst_q) begin
        drv = bang_off_q;
      end else if (cur <= tgt - hyst_q) begin
        drv = bang_on_q;
      end
    end
    // sanity tracker
    if (tgt > cur + window) begin
      if (cur > sane_q) begin
        sane_q = cur;
      end else if (lag_q < int'(HEAT_LAG_TICKS)) begin
        lag_q++;
      end else begin
        lag_q = 0;
        sane_q++;
      end
      if (sane_q > tgt) sane_q = tgt;
    end else if (tgt < cur - window) begin
      if (cur < sane_q) begin
        sane_q = cur;
      end else if (lag_q < int'(COOL_LAG_TICKS)) begin
        lag_q++;
      end else begin
        lag_q = 0;
        sane_q--;
      end
      if (cur <= int'(COOL_FLOOR)) begin
        sane_q = cur;
      end else if (sane_q < tgt) begin
        sane_q = tgt;
      end
    end else begin
      sane_q = cur;
      lag_q  = 0;
    end
    diff = cur - sane_q;
    if (diff < 0) diff = -diff;
    if (diff > window) begin
      drv = '0;
      flt = 1'b1;
    end
    last_drive_q = drv;
    r.drive = drv;
    r.fault = flt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    heater_cmd_t want;
    if (!rst_ni) begin
      p_gain_q     = CFG_RESET.p_gain;
      i_gain_q     = CFG_RESET.i_gain;
      d_gain_q     = CFG_RESET.d_gain;
      limit_q      = int'(CFG_RESET.integral_limit);
      hyst_q       = int'(CFG_RESET.hysteresis);
      mode_q       = CFG_RESET.mode;
      bang_on_q    = CFG_RESET.bang_on_level;
      bang_off_q   = CFG_RESET.bang_off_level;
      integ_q      = 0;
      hist_ptr_q   = 0;
      last_drive_q = '0;
      sane_q       = 0;
      lag_q        = 0;
      for (int k = 0; k < HISTORY_DEPTH_DEF; k++) hist_q[k] = 0;
      heater_cmd_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_P_GAIN:     p_gain_q   = cfg_data_i;
          CFG_I_GAIN:     i_gain_q   = cfg_data_i;
          CFG_D_GAIN:     d_gain_q   = cfg_data_i;
          CFG_INT_LIMIT:  limit_q    = int'(cfg_data_i[LIMIT_W-1:0]);
          CFG_HYSTERESIS: hyst_q     = int'(cfg_data_i[HYST_W-1:0]);
          CFG_MODE:       mode_q     = ctrl_mode_e'(cfg_data_i[0]);
          CFG_BANG_ON:    bang_on_q  = cfg_data_i[DRIVE_W-1:0];
          CFG_BANG_OFF:   bang_off_q = cfg_data_i[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        heater_cmd_q.push_back(predict_tick(int'(measured_temp_i), int'(setpoint_i)));
      end
      if (out_valid_i && out_ready_i) begin
        if (heater_cmd_q.size() == 0) begin
          $error("unexpected result transaction: drive %0d, sensor_fault %0b",
                 drive_i, sensor_fault_i);
          mismatches++;
        end else begin
          want = heater_cmd_q.pop_front();
          if (drive_i !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d", want.drive, drive_i);
            mismatches++;
          end
          if (sensor_fault_i !== want.fault) begin
            $error("sensor_fault mismatch: expected %0b, actual %0b",
                   want.fault, sensor_fault_i);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= heater_cmd_q.size();
    end
  end

endmodule

// File: bench/heater_pid_with_sanity_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_pid_with_sanity_check_tb
// drives temperature samples and register writes into the heater controller,
// with random idle and stall phases; a checker beside the block predicts and
// compares every result, and this top gives the verdict
// ----------------------------------------------------------------------------
module heater_pid_with_sanity_check_tb import hpsc_pkg::*; ();

  localparam int DRAIN_CYCLES   = 8;    // pipeline depth plus margin
  localparam int WATCHDOG_LIMIT = 1000; // cycles with no transaction at all
  localparam int RANDOM_ITEMS   = 720;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [TEMP_W-1:0]    measured;
  logic [TEMP_W-1:0]    target;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DRIVE_W-1:0]   drive;
  logic                 sensor_fault;

  int                   fail_count;
  int                   pending;
  int                   send_idle_pct = 0;  // chance the sender idles a cycle
  int                   stall_pct     = 0;  // chance the receiver stalls a cycle
  int unsigned          samples_sent  = 0;
  int                   idle_cycles   = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  heater_pid_with_sanity_check i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .measured_temp_i (measured),
    .setpoint_i      (target),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .drive_o         (drive),
    .sensor_fault_o  (sensor_fault)
  );

  heater_pid_with_sanity_check_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .measured_temp_i (measured),
    .setpoint_i      (target),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .drive_i         (drive),
    .sensor_fault_i  (sensor_fault),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // result side: random backpressure, changed at the falling edge
  always @(negedge clk) begin
    out_ready = (int'($urandom_range(99)) >= stall_pct);
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one sample transaction; starts and ends at a falling edge
  task automatic send_sample(input int meas, input int tgt);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    measured = meas[TEMP_W-1:0];
    target   = tgt[TEMP_W-1:0];
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every predicted result is out, then let the
  // pipeline settle so the block is truly idle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(input cfg_idx_e idx, input logic [GAIN_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    wait_drained();
    write_reg(CFG_P_GAIN,     s.p_gain);
    write_reg(CFG_I_GAIN,     s.i_gain);
    write_reg(CFG_D_GAIN,     s.d_gain);
    write_reg(CFG_INT_LIMIT,  {{(GAIN_W-LIMIT_W){1'b0}}, s.integral_limit});
    write_reg(CFG_HYSTERESIS, {{(GAIN_W-HYST_W){1'b0}}, s.hysteresis});
    write_reg(CFG_MODE,       {{(GAIN_W-1){1'b0}}, s.mode});
    write_reg(CFG_BANG_ON,    {{(GAIN_W-DRIVE_W){1'b0}}, s.bang_on_level});
    write_reg(CFG_BANG_OFF,   {{(GAIN_W-DRIVE_W){1'b0}}, s.bang_off_level});
    cfg_valid = 1'b0;
  endtask

  // gains: mostly moderate so the drive moves inside 0..255, some extremes
  function automatic logic [GAIN_W-1:0] pick_gain(input int span);
    int unsigned r;
    int          v;
    r = $urandom_range(15);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return $urandom();
    if (r == 3) return '0;
    v = int'($urandom_range(2 * span)) - span;
    return v;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    int unsigned r;
    s.p_gain = pick_gain(8192);
    s.i_gain = pick_gain(512);
    s.d_gain = pick_gain(4096);
    r = $urandom_range(7);
    if (r == 0) s.integral_limit = '0;
    else if (r == 1) s.integral_limit = 15'h7FFF;
    else s.integral_limit = LIMIT_W'($urandom_range(2000));
    r = $urandom_range(9);
    if (r == 0) s.hysteresis = '0;
    else if (r == 1) s.hysteresis = 8'hFF;
    else s.hysteresis = HYST_W'($urandom_range(1, 16));
    s.mode           = ctrl_mode_e'($urandom_range(1));
    s.bang_on_level  = DRIVE_W'($urandom_range(255));
    s.bang_off_level = DRIVE_W'($urandom_range(255));
    return s;
  endfunction

  initial begin
    cfg_t        s;
    int          kind;
    int          len;
    int          cur;
    int          tgt;
    int          move;
    int          window;
    int          seg;
    bit          pause_mid;
    // every input known from time zero
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_P_GAIN;
    cfg_data  = '0;
    in_valid  = 1'b0;
    measured  = '0;
    target    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ---------------- directed part, no idling ----------------
    s = CFG_RESET;
    s.p_gain         = 32'sd2048;
    s.i_gain         = 32'sd64;
    s.d_gain         = 32'sd512;
    s.integral_limit = 15'd100;
    apply_settings(s);
    send_sample(4095, 0);    // heater off, nothing moves
    send_sample(0, 0);
    send_sample(0, 4095);    // full error: saturates high, integral backs out
    send_sample(4095, 1);    // saturates low while cooling
    send_sample(1000, 1000); // near target, tracker follows
    send_sample(1000, 1002);
    send_sample(1000, 4000); // heating, tracker holds and its lag counter starts
    send_sample(900, 4000);  // temperature falls while heating: fault
    send_sample(3000, 3000);
    send_sample(3100, 1000); // temperature rises while cooling: fault
    send_sample(200, 10);    // below the cooling floor the tracker follows

    // gain extremes, widest integral clamp, zero hysteresis
    s.p_gain         = 32'h7FFF_FFFF;
    s.i_gain         = 32'h8000_0000;
    s.d_gain         = 32'h7FFF_FFFF;
    s.integral_limit = 15'h7FFF;
    s.hysteresis     = 8'd0;
    apply_settings(s);
    send_sample(4095, 1);
    send_sample(0, 4095);
    send_sample(1, 4095);
    send_sample(2048, 2048);

    // opposite extremes, integral clamped to zero, widest hysteresis
    s.p_gain         = 32'h8000_0000;
    s.i_gain         = 32'h7FFF_FFFF;
    s.d_gain         = 32'h8000_0000;
    s.integral_limit = 15'd0;
    s.hysteresis     = 8'hFF;
    apply_settings(s);
    send_sample(0, 4095);
    send_sample(4095, 4095);

    // bang-bang: switch on, hold in the dead band, switch off, hold
    s.mode           = MODE_BANG;
    s.hysteresis     = 8'd8;
    s.bang_on_level  = 8'd200;
    s.bang_off_level = 8'd17;
    apply_settings(s);
    send_sample(1000, 1000);
    send_sample(990, 1000);
    send_sample(995, 1000);
    send_sample(1010, 1000);
    send_sample(1000, 1000);

    // bang-bang with zero hysteresis and full-range levels
    s.hysteresis     = 8'd0;
    s.bang_on_level  = 8'hFF;
    s.bang_off_level = 8'h00;
    apply_settings(s);
    send_sample(500, 500);
    send_sample(499, 500);

    // ---------------- random part ----------------
    samples_sent = 0;
    seg = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      // four idling phases over the run
      case ((samples_sent * 4) / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      // mostly a fresh setting, sometimes the state keeps evolving
      if (seg == 0 || $urandom_range(3) != 0) begin
        s = random_settings();
        apply_settings(s);
      end
      window = 4 * int'(s.hysteresis);
      pause_mid = ($urandom_range(4) == 0);
      kind = $urandom_range(19);
      if (kind < 10) begin
        // heater ramping toward its setpoint with sensor jitter
        tgt = $urandom_range(1, 4095);
        cur = $urandom_range(4095);
        len = $urandom_range(20, 60);
        for (int n = 0; n < len; n++) begin
          if (pause_mid && n == len / 2) wait_drained();
          if ($urandom_range(29) == 0) begin
            send_sample(cur, 0);
          end else begin
            send_sample(cur, tgt);
          end
          move = (tgt - cur) / 8 + int'($urandom_range(6)) - 3;
          cur += move;
          if (cur < 0) cur = 0;
          if (cur > 4095) cur = 4095;
        end
      end else if (kind < 14) begin
        // heater stuck cold: lag counter runs out, tracker creeps upward
        cur = $urandom_range(1, 2000);
        tgt = cur + window + int'($urandom_range(1, 500));
        if (tgt > 4095) tgt = 4095;
        len = $urandom_range(45, 90);
        send_sample(cur, cur);
        for (int n = 0; n < len; n++) begin
          if (pause_mid && n == len / 2) wait_drained();
          send_sample(cur, tgt);
          if ($urandom_range(3) == 0 && cur > 1) cur--;
        end
      end else if (kind == 14) begin
        // heater stuck hot: long cooling lag, tracker creeps downward
        cur = $urandom_range(2500, 4095);
        tgt = cur - window - int'($urandom_range(1, 500));
        if (tgt < 1) tgt = 1;
        len = $urandom_range(128, 140);
        send_sample(cur, cur);
        for (int n = 0; n < len; n++) begin
          send_sample(cur, tgt);
        end
      end else begin
        // unrelated samples, setpoint sometimes off
        len = $urandom_range(10, 30);
        for (int n = 0; n < len; n++) begin
          if (pause_mid && n == len / 2) wait_drained();
          cur = $urandom_range(4095);
          tgt = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(4095));
          send_sample(cur, tgt);
        end
      end
      seg++;
    end

    // drain and settle, then the verdict
    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hpsc_pkg.sv
hw/rtl/hpsc_history.sv
hw/rtl/hpsc_core.sv
hw/rtl/hpsc_divider.sv
hw/rtl/heater_pid_with_sanity_check.sv
bench/heater_pid_with_sanity_check_checker.sv
bench/heater_pid_with_sanity_check_tb.sv
